FILE: rtl/tt2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle transform package
// Request codes, controller/datapath command types, the quarter-wave sine
// table and the angle folding helper.
// ----------------------------------------------------------------------------
package tt2d_pkg;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_TRANSLATE = 2'd1,
      OP_SCALE     = 2'd2,
      OP_ROTATE    = 2'd3
   } op_type;

   localparam int VERTEX_COUNT  = 3;
   localparam int CENTROID_DIV  = 3;
   localparam int DIV_DIGITS    = 4;
   localparam int TABLE_FRAC    = 14;
   localparam int DEG_QUARTER   = 90;
   localparam int DEG_HALF      = 180;
   localparam int DEG_3QUARTER  = 270;
   localparam int DEG_FULL      = 360;

   // Angle reduction: offset makes any 16-bit angle positive while keeping it
   // congruent modulo a full turn, then a reciprocal multiply estimates the
   // quotient (never too high, at most one low).
   localparam int ANG_U_W       = 17;
   localparam int ANG_PROD_W    = 34;
   localparam int ANGLE_OFFSET  = 33120;
   localparam int ANGLE_RECIP   = 93206;
   localparam int RECIP_SHIFT   = 25;

   localparam logic [14:0] SIN_Q14 [0:90] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   typedef struct packed {
      logic [6:0] idx;
      logic       neg;
   } trig_fold_type;

   typedef struct packed {
      logic       capture;
      logic       load_write;
      logic       div_step;
      logic       centroid;
      logic       mul;
      logic       sum;
      logic       write_back;
      logic [1:0] vidx;
      op_type     op;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic logic [14:0] sin_lookup(input logic [6:0] idx);
      if (idx > 7'(DEG_QUARTER)) begin
         return 15'd0;
      end
      return SIN_Q14[idx];
   endfunction

   // Maps an angle in 0..359 onto the quarter-wave table and a sign.
   function automatic trig_fold_type trig_fold(input logic [8:0] deg);
      trig_fold_type f;
      logic [8:0]    d;
      d = 9'd0;
      if (deg <= 9'(DEG_QUARTER)) begin
         d     = deg;
         f.neg = 1'b0;
      end else if (deg <= 9'(DEG_HALF)) begin
         d     = 9'(DEG_HALF) - deg;
         f.neg = 1'b0;
      end else if (deg <= 9'(DEG_3QUARTER)) begin
         d     = deg - 9'(DEG_HALF);
         f.neg = 1'b1;
      end else begin
         d     = 9'(DEG_FULL) - deg;
         f.neg = 1'b1;
      end
      f.idx = d[6:0];
      return f;
   endfunction

endpackage

FILE: rtl/triangle_transform_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle transform unit
// Holds three triangle vertices and applies load, translate, scale and
// rotate-about-centroid requests, reporting the three new vertices in turn.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Carries
//   req_*     in          req_valid/req_stall    one request beat (load or transform)
//   rsp_*     out         rsp_valid/rsp_stall    one vertex beat, rsp_last on vertex 2
//
// A load beat writes its vertex at once when it is taken; it yields no result
// beat. A translate or scale beat is captured and then each vertex passes
// through a multiply, a sum and a write-back step of the shared datapath.
// A rotate beat first runs the radix-16 divide-by-three that forms the centroid.
// Reset is synchronous and clears the stored vertices to zero and the control.
// A stalled result beat holds the write-back of the next vertex; a new request
// is accepted as soon as the third vertex has moved into the result register.
//
// The stored coordinates are COORD_WIDTH bits wide and saturate at that width;
// the ports stay 16 bits, so wider coordinates are reported by their low bits.
// Scale factors carry SCALE_FRAC_BITS fraction bits and the product is truncated
// toward zero. Rotation uses a quarter-wave sine table rescaled to
// TRIG_FRAC_BITS fraction bits, forms each rotated coordinate exactly and
// rounds it half away from zero once before adding the centroid back.
// ----------------------------------------------------------------------------
module triangle_transform_2d #(
   parameter int COORD_WIDTH     = 16,
   parameter int SCALE_FRAC_BITS = 8,
   parameter int TRIG_FRAC_BITS  = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [1:0]         req_vertex_index,
   input  logic signed [15:0] req_x_in,
   input  logic signed [15:0] req_y_in,
   input  logic signed [15:0] req_shift_x,
   input  logic signed [15:0] req_shift_y,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [15:0] req_angle_deg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_index,
   output logic signed [15:0] rsp_x_out,
   output logic signed [15:0] rsp_y_out,
   output logic               rsp_last
);

   // Commands flow from the controller to the datapath; the datapath only
   // reports whether the result register can take another vertex.
   tt2d_pkg::dp_cmd_type    cmd;
   tt2d_pkg::dp_status_type status;

   tt2d_ctrl #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tt2d_datapath #(
      .COORD_WIDTH     (COORD_WIDTH),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
      .TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_vertex_index (req_vertex_index),
      .req_x_in         (req_x_in),
      .req_y_in         (req_y_in),
      .req_shift_x      (req_shift_x),
      .req_shift_y      (req_shift_y),
      .req_scale_x      (req_scale_x),
      .req_scale_y      (req_scale_y),
      .req_angle_deg    (req_angle_deg),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_index    (rsp_out_index),
      .rsp_x_out        (rsp_x_out),
      .rsp_y_out        (rsp_y_out),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: rtl/tt2d_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle transform controller
// Sequences request capture, the centroid division and the per-vertex
// multiply, sum and write-back steps of the datapath.
// ----------------------------------------------------------------------------
module tt2d_ctrl #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_type,
   output logic                   req_stall,
   output tt2d_pkg::dp_cmd_type   cmd,
   input  tt2d_pkg::dp_status_type status
);

   localparam int DIV_STEPS = ((COORD_WIDTH + 2) + tt2d_pkg::DIV_DIGITS - 1)
                              / tt2d_pkg::DIV_DIGITS;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CENT,
      ST_MUL,
      ST_SUM,
      ST_WB
   } state_type;

   state_type            state_ff;
   tt2d_pkg::op_type     op_ff;
   logic [1:0]           vidx_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 stall_ff;
   logic                 accept;
   tt2d_pkg::op_type     req_op;

   assign req_op    = tt2d_pkg::op_type'(req_type);
   assign accept    = req_valid && !stall_ff;
   assign req_stall = stall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= tt2d_pkg::OP_LOAD;
         vidx_ff  <= 2'd0;
         cnt_ff   <= '0;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_op != tt2d_pkg::OP_LOAD)) begin
                  op_ff    <= req_op;
                  vidx_ff  <= 2'd0;
                  cnt_ff   <= '0;
                  stall_ff <= 1'b1;
                  state_ff <= (req_op == tt2d_pkg::OP_ROTATE) ? ST_DIV : ST_MUL;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_CENT;
               end
            end
            ST_CENT: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               state_ff <= ST_WB;
            end
            ST_WB: begin
               if (status.out_free) begin
                  if (vidx_ff == 2'(tt2d_pkg::VERTEX_COUNT - 1)) begin
                     stall_ff <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else begin
                     vidx_ff  <= vidx_ff + 2'd1;
                     state_ff <= ST_MUL;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = accept;
      cmd.load_write = accept && (req_op == tt2d_pkg::OP_LOAD);
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.centroid   = (state_ff == ST_CENT);
      cmd.mul        = (state_ff == ST_MUL);
      cmd.sum        = (state_ff == ST_SUM);
      cmd.write_back = (state_ff == ST_WB) && status.out_free;
      cmd.vidx       = vidx_ff;
      cmd.op         = op_ff;
   end

endmodule

FILE: rtl/tt2d_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle transform datapath
// Vertex store, angle reduction and sine lookup, divide-by-three unit for the
// centroid, shared multipliers and the rounding, saturating write-back.
// ----------------------------------------------------------------------------
module tt2d_datapath #(
   parameter int COORD_WIDTH     = 16,
   parameter int SCALE_FRAC_BITS = 8,
   parameter int TRIG_FRAC_BITS  = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tt2d_pkg::dp_cmd_type    cmd,
   output tt2d_pkg::dp_status_type status,
   input  logic [1:0]              req_vertex_index,
   input  logic signed [15:0]      req_x_in,
   input  logic signed [15:0]      req_y_in,
   input  logic signed [15:0]      req_shift_x,
   input  logic signed [15:0]      req_shift_y,
   input  logic signed [15:0]      req_scale_x,
   input  logic signed [15:0]      req_scale_y,
   input  logic signed [15:0]      req_angle_deg,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_out_index,
   output logic signed [15:0]      rsp_x_out,
   output logic signed [15:0]      rsp_y_out,
   output logic                    rsp_last
);

   localparam int CW     = COORD_WIDTH;
   localparam int T_W    = TRIG_FRAC_BITS + 2;
   localparam int B_W    = (T_W > 16) ? T_W : 16;
   localparam int A_W    = CW + 1;
   localparam int P_W    = A_W + B_W;
   localparam int ACC_W  = P_W + 3;
   localparam int S_W    = CW + 2;
   localparam int DIV_W  = ((S_W + tt2d_pkg::DIV_DIGITS - 1) / tt2d_pkg::DIV_DIGITS)
                           * tt2d_pkg::DIV_DIGITS;
   localparam int T_DN   = (TRIG_FRAC_BITS < tt2d_pkg::TABLE_FRAC)
                           ? tt2d_pkg::TABLE_FRAC - TRIG_FRAC_BITS : 0;
   localparam int T_UP   = (TRIG_FRAC_BITS > tt2d_pkg::TABLE_FRAC)
                           ? TRIG_FRAC_BITS - tt2d_pkg::TABLE_FRAC : 0;
   localparam int T_HALF = (T_DN > 0) ? (1 << (T_DN - 1)) : 0;

   localparam logic signed [ACC_W-1:0] CMAX     = (ACC_W'(1) << (CW - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] CMIN     = ~CMAX;
   localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
   localparam logic signed [ACC_W-1:0] SC_BIAS  =
      (ACC_W'(1) << SCALE_FRAC_BITS) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] RND_POS  = ACC_W'(1) << (TRIG_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] RND_NEG  = RND_POS - ACC_W'(1);

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
      if (v > CMAX) begin
         return CMAX[CW-1:0];
      end
      if (v < CMIN) begin
         return CMIN[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   // Several radix-2 steps of long division by three; returns {remainder, word}.
   function automatic logic [DIV_W+1:0] div3_step(input logic [DIV_W-1:0] q_i,
                                                  input logic [1:0]       r_i);
      logic [DIV_W-1:0] q;
      logic [1:0]       r;
      logic [2:0]       t;
      q = q_i;
      r = r_i;
      for (int j = 0; j < tt2d_pkg::DIV_DIGITS; j++) begin
         t = {r, q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (t >= 3'(tt2d_pkg::CENTROID_DIV)) begin
            q[0] = 1'b1;
            r    = 2'(t - 3'(tt2d_pkg::CENTROID_DIV));
         end else begin
            r    = t[1:0];
         end
      end
      return {r, q};
   endfunction

   function automatic logic signed [T_W-1:0] trig_value(input logic [8:0] deg);
      tt2d_pkg::trig_fold_type f;
      logic [31:0]             v;
      logic [T_W-1:0]          mag;
      f   = tt2d_pkg::trig_fold(deg);
      v   = 32'(tt2d_pkg::sin_lookup(f.idx));
      v   = ((v + 32'(T_HALF)) >> T_DN) << T_UP;
      mag = v[T_W-1:0];
      return f.neg ? -mag : mag;
   endfunction

   // Stored vertices.
   logic signed [CW-1:0]    vx_ff [0:2];
   logic signed [CW-1:0]    vy_ff [0:2];

   // Captured request fields.
   logic signed [15:0]      shift_x_ff, shift_y_ff, scale_x_ff, scale_y_ff;

   // Angle reduction and trig.
   logic [tt2d_pkg::ANG_U_W-1:0]    ang_u_ff, ang_u_in;
   logic [tt2d_pkg::ANG_PROD_W-1:0] ang_prod_ff, ang_prod_in;
   logic [8:0]              a_ff, a_in, b_deg;
   logic signed [T_W-1:0]   sin_ff, cos_ff;

   // Centroid division.
   logic [DIV_W-1:0]        dq_x_ff, dq_y_ff, dq_x_in, dq_y_in;
   logic [1:0]              dr_x_ff, dr_y_ff;
   logic                    dneg_x_ff, dneg_y_ff;
   logic signed [CW-1:0]    cx_ff, cy_ff, cx_in, cy_in;

   // Per-vertex pipeline.
   logic signed [P_W-1:0]   m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [P_W-1:0]   m0_in, m1_in, m2_in, m3_in;
   logic signed [ACC_W-1:0] sum_x_ff, sum_y_ff, sum_x_in, sum_y_in;
   logic signed [CW-1:0]    new_x, new_y, load_x, load_y;

   // Result register.
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_index_ff;
   logic signed [CW-1:0]    rsp_x_ff, rsp_y_ff;
   logic                    rsp_last_ff;

   logic signed [CW-1:0]    cur_x, cur_y;

   assign cur_x = vx_ff[cmd.vidx];
   assign cur_y = vy_ff[cmd.vidx];

   assign load_x = sat_coord({{(ACC_W - 16){req_x_in[15]}}, req_x_in});
   assign load_y = sat_coord({{(ACC_W - 16){req_y_in[15]}}, req_y_in});

   // Capture: angle offset and reciprocal product, centroid dividend.
   logic [17:0]             ang_full;
   logic signed [S_W-1:0]   sum3_x, sum3_y;
   logic [S_W-1:0]          mag_x, mag_y;

   always_comb begin
      ang_full    = {{2{req_angle_deg[15]}}, req_angle_deg} + 18'(tt2d_pkg::ANGLE_OFFSET);
      ang_u_in    = ang_full[tt2d_pkg::ANG_U_W-1:0];
      ang_prod_in = {17'd0, ang_u_in} * tt2d_pkg::ANG_PROD_W'(tt2d_pkg::ANGLE_RECIP);
      sum3_x      = S_W'(vx_ff[0]) + S_W'(vx_ff[1]) + S_W'(vx_ff[2]);
      sum3_y      = S_W'(vy_ff[0]) + S_W'(vy_ff[1]) + S_W'(vy_ff[2]);
      mag_x       = sum3_x[S_W-1] ? S_W'(-sum3_x) : S_W'(sum3_x);
      mag_y       = sum3_y[S_W-1] ? S_W'(-sum3_y) : S_W'(sum3_y);
   end

   // Remainder of the reduced angle, corrected once.
   logic [8:0]                    ang_q;
   logic [tt2d_pkg::ANG_U_W-1:0]  ang_r;

   always_comb begin
      ang_q = ang_prod_ff[tt2d_pkg::RECIP_SHIFT +: 9];
      ang_r = ang_u_ff - tt2d_pkg::ANG_U_W'(ang_q) * tt2d_pkg::ANG_U_W'(tt2d_pkg::DEG_FULL);
      if (ang_r >= tt2d_pkg::ANG_U_W'(tt2d_pkg::DEG_FULL)) begin
         ang_r = ang_r - tt2d_pkg::ANG_U_W'(tt2d_pkg::DEG_FULL);
      end
      a_in  = ang_r[8:0];
      b_deg = a_ff + 9'(tt2d_pkg::DEG_QUARTER);
      if (b_deg >= 9'(tt2d_pkg::DEG_FULL)) begin
         b_deg = b_deg - 9'(tt2d_pkg::DEG_FULL);
      end
   end

   // Divide-by-three steps and the signed centroid.
   logic [DIV_W+1:0] step_x, step_y;
   logic [CW:0]      qx, qy, nqx, nqy;

   always_comb begin
      step_x  = div3_step(dq_x_ff, dr_x_ff);
      step_y  = div3_step(dq_y_ff, dr_y_ff);
      dq_x_in = step_x[DIV_W-1:0];
      dq_y_in = step_y[DIV_W-1:0];
      qx      = dq_x_ff[CW:0];
      qy      = dq_y_ff[CW:0];
      nqx     = -qx;
      nqy     = -qy;
      cx_in   = dneg_x_ff ? nqx[CW-1:0] : qx[CW-1:0];
      cy_in   = dneg_y_ff ? nqy[CW-1:0] : qy[CW-1:0];
   end

   // Multiplier operands: offsets from the centroid for rotation, raw
   // coordinates for scaling.
   logic signed [A_W-1:0] op_x, op_y;
   logic signed [B_W-1:0] op_bx, op_by, sin_b;

   always_comb begin
      sin_b = B_W'(sin_ff);
      if (cmd.op == tt2d_pkg::OP_ROTATE) begin
         op_x  = A_W'(cur_x) - A_W'(cx_ff);
         op_y  = A_W'(cur_y) - A_W'(cy_ff);
         op_bx = B_W'(cos_ff);
         op_by = B_W'(cos_ff);
      end else begin
         op_x  = A_W'(cur_x);
         op_y  = A_W'(cur_y);
         op_bx = B_W'(scale_x_ff);
         op_by = B_W'(scale_y_ff);
      end
      m0_in = op_x * op_bx;
      m1_in = op_y * op_by;
      m2_in = op_x * sin_b;
      m3_in = op_y * sin_b;
   end

   // Sum stage.
   logic signed [ACC_W-1:0] ext_m0, ext_m1;

   always_comb begin
      ext_m0 = ACC_W'(m0_ff);
      ext_m1 = ACC_W'(m1_ff);
      unique case (cmd.op)
         tt2d_pkg::OP_ROTATE: begin
            sum_x_in = ext_m0 - ACC_W'(m3_ff);
            sum_y_in = ACC_W'(m2_ff) + ext_m1;
         end
         tt2d_pkg::OP_SCALE: begin
            // Bias negative products so that the shift truncates toward zero.
            sum_x_in = ext_m0 + (ext_m0[ACC_W-1] ? SC_BIAS : ACC_ZERO);
            sum_y_in = ext_m1 + (ext_m1[ACC_W-1] ? SC_BIAS : ACC_ZERO);
         end
         default: begin
            sum_x_in = ACC_W'(cur_x) + ACC_W'(shift_x_ff);
            sum_y_in = ACC_W'(cur_y) + ACC_W'(shift_y_ff);
         end
      endcase
   end

   // Write-back stage: round half away from zero for rotation, then saturate.
   logic signed [ACC_W-1:0] rnd_x, rnd_y, fin_x, fin_y;

   always_comb begin
      rnd_x = sum_x_ff + (sum_x_ff[ACC_W-1] ? RND_NEG : RND_POS);
      rnd_y = sum_y_ff + (sum_y_ff[ACC_W-1] ? RND_NEG : RND_POS);
      unique case (cmd.op)
         tt2d_pkg::OP_ROTATE: begin
            fin_x = (rnd_x >>> TRIG_FRAC_BITS) + ACC_W'(cx_ff);
            fin_y = (rnd_y >>> TRIG_FRAC_BITS) + ACC_W'(cy_ff);
         end
         tt2d_pkg::OP_SCALE: begin
            fin_x = sum_x_ff >>> SCALE_FRAC_BITS;
            fin_y = sum_y_ff >>> SCALE_FRAC_BITS;
         end
         default: begin
            fin_x = sum_x_ff;
            fin_y = sum_y_ff;
         end
      endcase
      new_x = sat_coord(fin_x);
      new_y = sat_coord(fin_y);
   end

   // Vertex store.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tt2d_pkg::VERTEX_COUNT; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
         end
      end else if (cmd.load_write) begin
         if (req_vertex_index != 2'(tt2d_pkg::VERTEX_COUNT)) begin
            vx_ff[req_vertex_index] <= load_x;
            vy_ff[req_vertex_index] <= load_y;
         end
      end else if (cmd.write_back) begin
         vx_ff[cmd.vidx] <= new_x;
         vy_ff[cmd.vidx] <= new_y;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         shift_x_ff  <= req_shift_x;
         shift_y_ff  <= req_shift_y;
         scale_x_ff  <= req_scale_x;
         scale_y_ff  <= req_scale_y;
         ang_u_ff    <= ang_u_in;
         ang_prod_ff <= ang_prod_in;
         dq_x_ff     <= DIV_W'(mag_x);
         dq_y_ff     <= DIV_W'(mag_y);
         dr_x_ff     <= 2'd0;
         dr_y_ff     <= 2'd0;
         dneg_x_ff   <= sum3_x[S_W-1];
         dneg_y_ff   <= sum3_y[S_W-1];
      end
      if (cmd.div_step) begin
         dq_x_ff <= dq_x_in;
         dq_y_ff <= dq_y_in;
         dr_x_ff <= step_x[DIV_W+1:DIV_W];
         dr_y_ff <= step_y[DIV_W+1:DIV_W];
         a_ff    <= a_in;
         sin_ff  <= trig_value(a_ff);
         cos_ff  <= trig_value(b_deg);
      end
      if (cmd.centroid) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
      if (cmd.mul) begin
         m0_ff <= m0_in;
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         m3_ff <= m3_in;
      end
      if (cmd.sum) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write_back) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_back) begin
         rsp_index_ff <= cmd.vidx;
         rsp_x_ff     <= new_x;
         rsp_y_ff     <= new_y;
         rsp_last_ff  <= (cmd.vidx == 2'(tt2d_pkg::VERTEX_COUNT - 1));
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_index   = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;

   generate
      if (CW >= 16) begin : g_out_trunc
         assign rsp_x_out = rsp_x_ff[15:0];
         assign rsp_y_out = rsp_y_ff[15:0];
      end else begin : g_out_sext
         assign rsp_x_out = {{(16 - CW){rsp_x_ff[CW-1]}}, rsp_x_ff};
         assign rsp_y_out = {{(16 - CW){rsp_y_ff[CW-1]}}, rsp_y_ff};
      end
   endgenerate

endmodule
